[hdl/sync_hub_pulse_generator_top_assert.svh]
// assertion helpers used by the pulse generator back end
`ifndef SYNC_HUB_PULSE_GENERATOR_TOP_ASSERT_SVH
`define SYNC_HUB_PULSE_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SHPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/shpg_pkg.sv]
package shpg_pkg;

    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int RATE_W     = 10;
    localparam int HALF_W     = 20;
    localparam int PULSE_W    = 10;
    localparam int DLY_W      = 16;
    localparam int PERIOD_W   = 20;
    localparam int EVT_W      = 8;
    localparam int MS_W       = 16;
    localparam int CMD_W      = 3;
    localparam int OUT_W      = 16;

    localparam logic [HALF_W-1:0]   HALF_RST       = 20'd500000;
    localparam logic [PULSE_W-1:0]  PULSE_RST      = 10'd100;
    localparam logic [DLY_W-1:0]    SETTLE_RST     = 16'd500;
    localparam logic [DLY_W-1:0]    STROBE_RST     = 16'd1000;
    localparam logic [DLY_W-1:0]    CLEAR_RST      = 16'd500;
    localparam logic [PERIOD_W-1:0] CAM_PERIOD_RST = 20'd16666;
    localparam logic [PERIOD_W-1:0] US_PER_S       = 20'd1000000;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int DIV_STEPS  = PERIOD_W;
    localparam int DIV_CNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE       = 3'd0,
        CMD_SYNC_START = 3'd1,
        CMD_SYNC_STOP  = 3'd2,
        CMD_CAM_START  = 3'd3,
        CMD_CAM_STOP   = 3'd4,
        CMD_EVENT      = 3'd5,
        CMD_REWARD     = 3'd6
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAM_RATE  = 3'd0,
        CFG_SYNC_HALF = 3'd1,
        CFG_CAM_PULSE = 3'd2,
        CFG_SETTLE    = 3'd3,
        CFG_STROBE    = 3'd4,
        CFG_CLEAR     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_STROBE = 2'd2,
        PH_CLEAR  = 2'd3
    } t_phase;

    typedef struct packed {
        t_cmd             cmd;
        logic             is_cmd;
        logic [EVT_W-1:0] event_value;
        logic [MS_W-1:0]  reward_ms;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [PERIOD_W-1:0] quo;
    } t_div_stat;

endpackage

[hdl/shpg_front.sv]
module shpg_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [shpg_pkg::CMD_W-1:0] i_cmd,
    input  logic [shpg_pkg::EVT_W-1:0] i_event_value,
    input  logic [shpg_pkg::MS_W-1:0]  i_reward_ms,
    input  logic                      i_full,
    output logic                      o_push,
    output shpg_pkg::t_item           o_item
);
    import shpg_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // unused code seven is classed as no command and never refused
    always_comb begin
        n_item.is_cmd      = (i_cmd >= CMD_SYNC_START) && (i_cmd <= CMD_REWARD);
        n_item.cmd         = n_item.is_cmd ? t_cmd'(i_cmd) : CMD_NONE;
        n_item.event_value = i_event_value;
        n_item.reward_ms   = i_reward_ms;
    end

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

[hdl/shpg_queue.sv]
module shpg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  shpg_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output shpg_pkg::t_item o_item
);
    import shpg_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hdl/shpg_div.sv]
module shpg_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shpg_pkg::t_div_req  i_req,
    output shpg_pkg::t_div_stat o_stat
);
    import shpg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [RATE_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_den;
    logic [PERIOD_W-1:0]  r_quo;

    logic [RATE_W:0]      rem_sh;
    logic                 fits;
    logic [RATE_W:0]      rem_sub;

    // restoring division, one quotient bit a cycle, dividend shifted out of r_quo
    always_comb begin
        rem_sh  = {r_rem, r_quo[PERIOD_W-1]};
        fits    = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= US_PER_S;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
            r_quo <= {r_quo[PERIOD_W-2:0], fits};
        end
    end

endmodule

[hdl/shpg_back.sv]
module shpg_back #(
    parameter int TICKS_PER_MS = 1000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [shpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [shpg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_q_valid,
    input  shpg_pkg::t_item               i_item,
    output logic                          o_pop,
    output shpg_pkg::t_div_req            o_div_req,
    input  shpg_pkg::t_div_stat           i_div_stat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [shpg_pkg::OUT_W-1:0]     o_data
);
    import shpg_pkg::*;
    `include "sync_hub_pulse_generator_top_assert.svh"

    localparam int PS_W = $clog2(TICKS_PER_MS + 1);
    localparam logic [PS_W-1:0] PS_TOP = PS_W'(TICKS_PER_MS);

    // configuration
    logic [HALF_W-1:0]   r_half;
    logic [PULSE_W-1:0]  r_pulse;
    logic [DLY_W-1:0]    r_settle;
    logic [DLY_W-1:0]    r_strobe;
    logic [DLY_W-1:0]    r_clear;
    logic [PERIOD_W-1:0] r_cam_period;

    // timing state
    logic                r_sync_on,    n_sync_on;
    logic                r_sync_level, n_sync_level;
    logic [HALF_W-1:0]   r_sync_count, n_sync_count;
    logic                r_cam_on,     n_cam_on;
    logic [PERIOD_W-1:0] r_cam_count,  n_cam_count;
    logic [PULSE_W-1:0]  r_pulse_left, n_pulse_left;
    t_phase              r_phase,      n_phase;
    logic [EVT_W-1:0]    r_event_held, n_event_held;
    logic [DLY_W-1:0]    r_phase_count, n_phase_count;
    logic [MS_W-1:0]     r_reward_left, n_reward_left;
    logic [PS_W-1:0]     r_ms_prescale, n_ms_prescale;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic [OUT_W-1:0]    n_out_data;

    logic                rate_wr;
    logic                div_hold;
    logic                busy_pre;
    logic                take;
    logic                refused;
    logic [HALF_W-1:0]   half_eff;
    logic [DLY_W-1:0]    strobe_eff;
    logic [HALF_W:0]     sync_inc;
    logic [PERIOD_W:0]   cam_inc;
    logic [PERIOD_W-1:0] pw_clip;
    logic [PULSE_W-1:0]  pulse_w;
    logic [PS_W-1:0]     ps_inc;
    logic                busy_post;

    assign rate_wr = i_cfg_we && (i_cfg_idx == CFG_CAM_RATE);
    // a fresh camera period must land before the next tick is worked
    assign div_hold = i_div_stat.busy || i_div_stat.done || rate_wr;
    assign o_pop    = i_q_valid && !div_hold && (!r_out_valid || i_ready);

    assign o_div_req.start = rate_wr;
    assign o_div_req.den   = (i_cfg_data[RATE_W-1:0] == '0) ?
                             RATE_W'(1) : i_cfg_data[RATE_W-1:0];

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_comb begin
        busy_pre   = (r_phase != PH_IDLE) || (r_reward_left != '0);
        take       = i_item.is_cmd && !busy_pre;
        refused    = i_item.is_cmd && busy_pre;
        half_eff   = (r_half == '0) ? HALF_W'(1) : r_half;
        strobe_eff = (r_strobe == '0) ? DLY_W'(1) : r_strobe;
        sync_inc   = {1'b0, r_sync_count} + 1'b1;
        cam_inc    = {1'b0, r_cam_count} + 1'b1;
        ps_inc     = r_ms_prescale + 1'b1;

        // trigger width kept below the period and at least one tick
        if (r_cam_period > PERIOD_W'(1) && {10'd0, r_pulse} >= r_cam_period) begin
            pw_clip = r_cam_period - 1'b1;
        end else begin
            pw_clip = {10'd0, r_pulse};
        end
        pulse_w = (pw_clip[PULSE_W-1:0] == '0) ? PULSE_W'(1) : pw_clip[PULSE_W-1:0];

        n_sync_on     = r_sync_on;
        n_sync_level  = r_sync_level;
        n_sync_count  = r_sync_count;
        n_cam_on      = r_cam_on;
        n_cam_count   = r_cam_count;
        n_pulse_left  = r_pulse_left;
        n_phase       = r_phase;
        n_event_held  = r_event_held;
        n_phase_count = r_phase_count;
        n_reward_left = r_reward_left;
        n_ms_prescale = r_ms_prescale;

        // sync square wave
        if (take && i_item.cmd == CMD_SYNC_START) begin
            n_sync_on    = 1'b1;
            n_sync_level = 1'b0;
            n_sync_count = '0;
        end else if (take && i_item.cmd == CMD_SYNC_STOP) begin
            n_sync_on    = 1'b0;
            n_sync_level = 1'b0;
            n_sync_count = '0;
        end else if (r_sync_on) begin
            if (sync_inc >= {1'b0, half_eff}) begin
                n_sync_count = '0;
                n_sync_level = !r_sync_level;
            end else begin
                n_sync_count = sync_inc[HALF_W-1:0];
            end
        end

        // camera trigger
        if (take && i_item.cmd == CMD_CAM_START) begin
            n_cam_on     = 1'b1;
            n_cam_count  = '0;
            n_pulse_left = '0;
        end else if (take && i_item.cmd == CMD_CAM_STOP) begin
            n_cam_on     = 1'b0;
            n_cam_count  = '0;
            n_pulse_left = '0;
        end else if (r_cam_on) begin
            if (r_pulse_left != '0) begin
                n_pulse_left = r_pulse_left - 1'b1;
            end
            if (cam_inc >= {1'b0, r_cam_period}) begin
                n_cam_count  = '0;
                n_pulse_left = pulse_w;
            end else begin
                n_cam_count = cam_inc[PERIOD_W-1:0];
            end
        end

        // event sequence: advance, then fall through any phase with no time left
        if (take && i_item.cmd == CMD_EVENT) begin
            n_event_held  = i_item.event_value;
            n_phase       = PH_SETTLE;
            n_phase_count = r_settle;
        end else if (r_phase != PH_IDLE && r_phase_count != '0) begin
            n_phase_count = r_phase_count - 1'b1;
        end

        case (n_phase)
            PH_SETTLE: begin
                if (n_phase_count == '0) begin
                    n_phase       = PH_STROBE;
                    n_phase_count = strobe_eff;
                end
            end
            PH_STROBE: begin
                if (n_phase_count == '0) begin
                    n_phase_count = r_clear;
                    if (r_clear == '0) begin
                        n_phase      = PH_IDLE;
                        n_event_held = '0;
                    end else begin
                        n_phase = PH_CLEAR;
                    end
                end
            end
            PH_CLEAR: begin
                if (n_phase_count == '0) begin
                    n_phase      = PH_IDLE;
                    n_event_held = '0;
                end
            end
            default: begin
            end
        endcase

        // reward pulse in milliseconds
        if (take && i_item.cmd == CMD_REWARD) begin
            n_reward_left = i_item.reward_ms;
            n_ms_prescale = '0;
        end else if (r_reward_left != '0) begin
            if (ps_inc == PS_TOP) begin
                n_ms_prescale = '0;
                n_reward_left = r_reward_left - 1'b1;
            end else begin
                n_ms_prescale = ps_inc;
            end
        end

        busy_post  = (n_phase != PH_IDLE) || (n_reward_left != '0);
        n_out_data = {2'b00, refused, busy_post, (n_reward_left != '0),
                      (n_phase == PH_STROBE), n_event_held,
                      (n_cam_on && n_pulse_left != '0), (n_sync_on && n_sync_level)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half       <= HALF_RST;
            r_pulse      <= PULSE_RST;
            r_settle     <= SETTLE_RST;
            r_strobe     <= STROBE_RST;
            r_clear      <= CLEAR_RST;
            r_cam_period <= CAM_PERIOD_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_HALF: r_half   <= i_cfg_data[HALF_W-1:0];
                    CFG_CAM_PULSE: r_pulse  <= i_cfg_data[PULSE_W-1:0];
                    CFG_SETTLE:    r_settle <= i_cfg_data[DLY_W-1:0];
                    CFG_STROBE:    r_strobe <= i_cfg_data[DLY_W-1:0];
                    CFG_CLEAR:     r_clear  <= i_cfg_data[DLY_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_div_stat.done) begin
                r_cam_period <= i_div_stat.quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_on     <= 1'b0;
            r_sync_level  <= 1'b0;
            r_sync_count  <= '0;
            r_cam_on      <= 1'b0;
            r_cam_count   <= '0;
            r_pulse_left  <= '0;
            r_phase       <= PH_IDLE;
            r_event_held  <= '0;
            r_phase_count <= '0;
            r_reward_left <= '0;
            r_ms_prescale <= '0;
        end else if (o_pop) begin
            r_sync_on     <= n_sync_on;
            r_sync_level  <= n_sync_level;
            r_sync_count  <= n_sync_count;
            r_cam_on      <= n_cam_on;
            r_cam_count   <= n_cam_count;
            r_pulse_left  <= n_pulse_left;
            r_phase       <= n_phase;
            r_event_held  <= n_event_held;
            r_phase_count <= n_phase_count;
            r_reward_left <= n_reward_left;
            r_ms_prescale <= n_ms_prescale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

    `SHPG_ASSERT_NOW(a_idle_data_clear, i_clk, i_rst_n, r_phase == PH_IDLE, r_event_held == '0, "event data left driven while idle")
    `SHPG_ASSERT_NOW(a_phase_time_left, i_clk, i_rst_n, r_phase != PH_IDLE, r_phase_count != '0, "event phase kept with no time left")
    `SHPG_ASSERT_NOW(a_trigger_needs_cam, i_clk, i_rst_n, r_pulse_left != '0, r_cam_on, "trigger pulse pending with camera stopped")
    `SHPG_ASSERT_NEXT(a_period_steady, i_clk, i_rst_n, o_pop, $stable(r_cam_period), "camera period changed under a tick")

endmodule

[hdl/sync_hub_pulse_generator_top.sv]
// channel  | dir | handshake             | payload
// ---------+-----+-----------------------+------------------------------------------
// s_axis   | in  | tvalid / tready       | tuser: command; tdata: event_value, reward_ms
// m_axis   | out | tvalid / tready       | tdata: sync .. refused, one request per tick
// cfg      | in  | i_cfg_we, no wait     | i_cfg_idx register index, i_cfg_data value
//
// sustains one tick request per clock while m_axis is ready and no rate write holds
// the back end; a result passes the front stage, the queue and the output register.
// a camera rate write holds the back end through the write cycle, twenty divider
// steps and the period load; the front keeps taking requests until the
// four-entry queue and the front stage are full.
// i_rst_n is synchronous, active low, and resets the control and state registers
// of all units but not the data registers; there is no clearing pass.
// m_axis stalls hold the result register and back up through the queue to s_axis.
module sync_hub_pulse_generator_top #(
    parameter int TICKS_PER_MS = 1000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] event_value, [23:8] reward_ms
    input  logic [23:0]                   s_axis_tdata,
    // [2:0] command
    input  logic [shpg_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] sync_line, [1] camera_line, [9:2] event_data, [10] strobe_line,
    // [11] reward_line, [12] busy_res, [13] refused, [15:14] zero
    output logic [shpg_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [shpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [shpg_pkg::CFG_W-1:0]     i_cfg_data
);
    import shpg_pkg::*;

    logic      fe_push;
    t_item     fe_item;
    logic      q_full;
    logic      q_valid;
    t_item     q_item;
    logic      be_pop;
    t_div_req  div_req;
    t_div_stat div_stat;

    shpg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_event_value (s_axis_tdata[7:0]),
        .i_reward_ms   (s_axis_tdata[23:8]),
        .i_full        (q_full),
        .o_push        (fe_push),
        .o_item        (fe_item)
    );

    shpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_item  (fe_item),
        .o_full  (q_full),
        .i_pop   (be_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    shpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    shpg_back #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_item     (q_item),
        .o_pop      (be_pop),
        .o_div_req  (div_req),
        .i_div_stat (div_stat),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule
